FILE: sv/csfw_pkg.sv
// Shared types, status codes and defaults for the counting semaphore block.
package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int COUNT_MAX_DEF   = 255;

  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_BLOCKED   = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_HANDOFF   = 3'd3;
  localparam logic [2:0] ST_QFULL     = 3'd4;
  localparam logic [2:0] ST_SATURATED = 3'd5;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] task_id;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       wake_valid;
    logic [7:0] wake_task;
    logic [7:0] count_now;
    logic [4:0] waiting_now;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // cfg beat: reload count, empty queue
    logic capture;  // input beat: latch request, read queue head
    logic exec;     // apply request, load result register
  } csfw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_hold;  // result register full and stalled
  } csfw_stat_t;

endpackage

FILE: sv/counting_semaphore_fifo_wait_core.sv
// Counting semaphore with FIFO wait queue: top level.
//
// Input channel (in_valid/in_stall/in_data): one beat is one request, an
// acquire or a release from a task id. Result channel (out_valid/out_stall/
// out_data): exactly one result beat per request, in request order.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes the initial count;
// the count is reloaded (clamped to COUNT_MAX) and the wait queue emptied.
//
// A request is latched at accept while the queue head is read from the wait
// RAM into its read register; the execute state then applies the request,
// updates count and pointers and loads the result register. A new request
// is not accepted until the previous one has executed.
// The result register lets the next request be accepted while a result
// waits. If the receiver stalls, a finished request holds in the execute
// state and in_stall stays high until the result register frees up.
// Reset (rst_n low, synchronous): count 0, queue empty, no result pending.
// Queue RAM contents are not cleared; only written entries are ever read.
module counting_semaphore_fifo_wait_core #(
  parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_MAX   = csfw_pkg::COUNT_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  csfw_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output csfw_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);
  import csfw_pkg::*;

  csfw_cmd_t  cmd;
  csfw_stat_t stat;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csfw_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .COUNT_MAX  (COUNT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/csfw_ctrl.sv
// Controller FSM: sequences accept and execute of one request at a time.
module csfw_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  csfw_pkg::csfw_stat_t   stat,
  output csfw_pkg::csfw_cmd_t    cmd
);
  import csfw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   idle;

  assign idle      = (state_r == S_IDLE);
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  always_comb begin
    cmd.load    = idle && cfg_valid;
    cmd.capture = idle && in_valid;
    cmd.exec    = 1'b0;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here until the result register can take the new result
        if (!stat.out_hold) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/csfw_dp.sv
// Datapath: semaphore count, wait queue pointers and RAM, result register.
module csfw_dp #(
  parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_MAX   = csfw_pkg::COUNT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csfw_pkg::in_t        in_data,
  input  logic [7:0]           cfg_data,
  input  csfw_pkg::csfw_cmd_t  cmd,
  output csfw_pkg::csfw_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csfw_pkg::out_t       out_data
);
  import csfw_pkg::*;

  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW+7:0] CMAX_EXT = (CW+8)'(COUNT_MAX);
  localparam logic [CW-1:0] CMAX     = CW'(COUNT_MAX);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [LW-1:0] FULL_LEN  = LW'(QUEUE_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] len_r, len_nxt;
  in_t           req_r;
  out_t          out_r;
  out_t          res;
  logic          out_valid_r;
  logic          push;
  logic [7:0]    head_id;
  logic [CW+7:0] init_ext;
  logic [CW-1:0] load_val;
  logic [CW+7:0] cnt_ext;
  logic [LW+4:0] len_ext;

  // clamp the configured count to the maximum
  assign init_ext = {{CW{1'b0}}, cfg_data};
  assign load_val = (init_ext > CMAX_EXT) ? CMAX : init_ext[CW-1:0];

  csfw_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (cmd.exec && push),
    .wr_addr (tail_r),
    .wr_data (req_r.task_id),
    .rd_en   (cmd.capture),
    .rd_addr (head_r),
    .rd_data (head_id)
  );

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    len_nxt        = len_r;
    push           = 1'b0;
    res.wake_valid = 1'b0;
    res.wake_task  = 8'd0;
    if (req_r.req_type == REQ_ACQUIRE) begin
      if (count_r != '0) begin
        count_nxt  = count_r - 1'b1;
        res.status = ST_ACQUIRED;
      end else if (len_r == FULL_LEN) begin
        res.status = ST_QFULL;
      end else begin
        push       = 1'b1;
        tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
        len_nxt    = len_r + 1'b1;
        res.status = ST_BLOCKED;
      end
    end else begin
      if (len_r != '0) begin
        // hand the unit straight to the oldest waiter
        res.wake_valid = 1'b1;
        res.wake_task  = head_id;
        head_nxt       = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
        len_nxt        = len_r - 1'b1;
        res.status     = ST_HANDOFF;
      end else if (count_r == CMAX) begin
        res.status = ST_SATURATED;
      end else begin
        count_nxt  = count_r + 1'b1;
        res.status = ST_RELEASED;
      end
    end
    cnt_ext         = {8'd0, count_nxt};
    len_ext         = {5'd0, len_nxt};
    res.count_now   = cnt_ext[7:0];
    res.waiting_now = len_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        count_r <= load_val;
        head_r  <= '0;
        tail_r  <= '0;
        len_r   <= '0;
      end else if (cmd.exec) begin
        count_r <= count_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        len_r   <= len_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= res;
    end
  end

  assign stat.out_hold = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

FILE: sv/csfw_checker.sv
// Port-level checker for the semaphore core, bound to the top level.
module csfw_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input csfw_pkg::out_t out_data
);
  import csfw_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one request in flight: the cycle after an accept the input is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // a wakeup comes exactly with a handoff
  a_wake_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.wake_valid == (out_data.status == ST_HANDOFF)))
    else $error("wake_valid does not match handoff status");

  a_wake_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.wake_valid |-> out_data.wake_task == 8'd0)
    else $error("wake_task nonzero without wakeup");

  // a blocked request leaves at least itself queued with a zero count
  a_blocked_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BLOCKED |->
      out_data.waiting_now != 5'd0 && out_data.count_now == 8'd0)
    else $error("blocked result with empty queue or nonzero count");

endmodule

bind counting_semaphore_fifo_wait_core csfw_checker u_csfw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
